/* hdl/prs_pkg.sv */
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the periodic release scheduler
// Time width, command codes, register map, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package prs_pkg;

  // time, period, index and counter width
  localparam int TIME_W = 64;
  // iteration counter width of the shared multiply/divide loop
  localparam int ITER_W = $clog2(TIME_W);
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 3;

  localparam logic [TIME_W-1:0] TMAX         = '1;
  localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(1000000);

  // event commands
  localparam logic [CMD_W-1:0] CMD_ADVANCE  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_COMPLETE = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_CLEAR    = CMD_W'(2);

  // register map
  localparam logic [ADDR_W-1:0] REG_PERIOD_ADDR = ADDR_W'(0);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN1,
    ST_FIN2,
    ST_COMMIT
  } prs_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic fin1;
    logic fin2;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic iter_last;
  } dp_stat_t;

endpackage

/* hdl/prs_ifs.sv */
// ----------------------------------------------------------------------------
// prs_ifs: event and result channels
// Valid/ready channels carrying one event item and one result item.
// ----------------------------------------------------------------------------
interface prs_in_if;
  import prs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TIME_W-1:0]   event_time_ns;

  modport source (output valid, command, event_time_ns, input ready);
  modport sink   (input valid, command, event_time_ns, output ready);
endinterface

interface prs_out_if;
  import prs_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [TIME_W-1:0]   release_time_ns;
  logic [TIME_W-1:0]   release_number;
  logic [TIME_W-1:0]   skipped_releases;
  logic [TIME_W-1:0]   late_step_count;
  logic [TIME_W-1:0]   worst_lateness_ns;

  modport source (output valid, ok, release_time_ns, release_number, skipped_releases,
                  late_step_count, worst_lateness_ns, input ready);
  modport sink   (input valid, ok, release_time_ns, release_number, skipped_releases,
                  late_step_count, worst_lateness_ns, output ready);
endinterface

/* hdl/prs_regs.sv */
// ----------------------------------------------------------------------------
// prs_regs: configuration register file
// Holds the schedule period, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module prs_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prs_pkg::ADDR_W-1:0]    paddr,
  input  logic [prs_pkg::TIME_W-1:0]    pwdata,
  output logic [prs_pkg::TIME_W-1:0]    prdata,
  output logic [prs_pkg::TIME_W-1:0]    period
);
  import prs_pkg::*;

  logic [TIME_W-1:0] period_r;
  logic              wr_en;

  // access phase write to the period register
  assign wr_en = psel & penable & pwrite & (paddr == REG_PERIOD_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (wr_en) begin
      period_r <= pwdata;
    end
  end

  // read back
  assign prdata = (paddr == REG_PERIOD_ADDR) ? period_r : '0;
  assign period = period_r;

endmodule

/* hdl/prs_ctrl.sv */
// ----------------------------------------------------------------------------
// prs_ctrl: event sequencer
// Accepts an event, runs the shared multiply/divide loop, steps through the
// finishing cycles and hands the result to the output register.
// ----------------------------------------------------------------------------
module prs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  prs_pkg::dp_stat_t  stat,
  output prs_pkg::dp_cmd_t   cmd
);
  import prs_pkg::*;

  prs_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       accept;

  // output slot can take a new result
  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_CALC;
      ST_CALC:   if (stat.iter_last) state_nxt = ST_FIN1;
      ST_FIN1:   state_nxt = ST_FIN2;
      ST_FIN2:   state_nxt = ST_COMMIT;
      ST_COMMIT: if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands and channel outputs
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CALC:   cmd.step   = 1'b1;
      ST_FIN1:   cmd.fin1   = 1'b1;
      ST_FIN2:   cmd.fin2   = 1'b1;
      ST_COMMIT: cmd.commit = slot_free;
      default:   cmd        = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/prs_dp.sv */
// ----------------------------------------------------------------------------
// prs_dp: schedule datapath
// Shift-add multiplier and restoring divider sharing one iteration counter,
// two finishing stages, the schedule state and the result register.
// ----------------------------------------------------------------------------
module prs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prs_pkg::dp_cmd_t              cmd,
  output prs_pkg::dp_stat_t             stat,
  input  logic [prs_pkg::CMD_W-1:0]     in_command,
  input  logic [prs_pkg::TIME_W-1:0]    in_time,
  input  logic [prs_pkg::TIME_W-1:0]    period,
  output logic                          out_ok,
  output logic [prs_pkg::TIME_W-1:0]    out_release_time,
  output logic [prs_pkg::TIME_W-1:0]    out_release_number,
  output logic [prs_pkg::TIME_W-1:0]    out_skipped,
  output logic [prs_pkg::TIME_W-1:0]    out_late_count,
  output logic [prs_pkg::TIME_W-1:0]    out_worst_late
);
  import prs_pkg::*;

  // event operands
  logic [CMD_W-1:0]    op_r;
  logic [TIME_W-1:0]   t_r;
  logic [TIME_W-1:0]   p_r;
  logic                pzero_r;

  // iteration state
  logic [ITER_W-1:0]   iter_r;
  logic [2*TIME_W-1:0] prod_r, prod_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [TIME_W-1:0]   quo_r, quo_nxt;
  logic [TIME_W:0]     mul_sum;
  logic [TIME_W:0]     div_shift;
  logic [TIME_W:0]     div_sub;
  logic                div_ge;

  // first finishing stage
  logic                cur_ovf;
  logic [TIME_W:0]     dl_sum;
  logic [TIME_W-1:0]   cur_rt_r, dl_r, ceil_r, base_r;
  logic                dl_ovf_r, rem_nz_r;

  // second finishing stage
  logic [TIME_W:0]     nrt_sum;
  logic [TIME_W-1:0]   nrt_r, late_r, dist_adv_r, dist_cmp_r;
  logic                le_cur_r, tgt_lt_r, tgt_max_r, is_late_r, ceil_gt_r, idx_max_r;

  // schedule state
  logic [TIME_W-1:0]   idx_r, idx_nxt;
  logic [TIME_W-1:0]   skip_r, skip_nxt;
  logic [TIME_W-1:0]   latecnt_r, latecnt_nxt;
  logic [TIME_W-1:0]   worst_r, worst_nxt;

  // result register
  logic                ok_r, ok_nxt;
  logic [TIME_W-1:0]   rt_r, rt_nxt;

  // one multiply step and one divide step per cycle
  always_comb begin
    mul_sum   = {1'b0, prod_r[2*TIME_W-1:TIME_W]} + (prod_r[0] ? {1'b0, idx_r} : '0);
    prod_nxt  = {mul_sum, prod_r[TIME_W-1:1]};
    div_shift = {rem_r, quo_r[TIME_W-1]};
    div_sub   = div_shift - {1'b0, p_r};
    div_ge    = div_shift >= {1'b0, p_r};
    rem_nxt   = div_ge ? div_sub[TIME_W-1:0] : div_shift[TIME_W-1:0];
    quo_nxt   = {quo_r[TIME_W-2:0], div_ge};
  end

  assign stat.iter_last = (iter_r == ITER_W'(TIME_W - 1));

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd.load) begin
      iter_r <= '0;
    end else if (cmd.step) begin
      iter_r <= iter_r + ITER_W'(1);
    end
  end

  // operand capture and iteration registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_command;
      t_r     <= in_time;
      p_r     <= period;
      pzero_r <= (period == '0);
      prod_r  <= {{TIME_W{1'b0}}, period};
      rem_r   <= '0;
      quo_r   <= in_time;
    end else if (cmd.step) begin
      prod_r  <= prod_nxt;
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
    end
  end

  // current release time, deadline, ceiling quotient
  assign cur_ovf = pzero_r | (prod_r[2*TIME_W-1:TIME_W] != '0);
  assign dl_sum  = {1'b0, prod_r[TIME_W-1:0]} + {1'b0, p_r};

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      cur_rt_r <= cur_ovf ? TMAX : prod_r[TIME_W-1:0];
      dl_r     <= dl_sum[TIME_W-1:0];
      dl_ovf_r <= cur_ovf | dl_sum[TIME_W];
      rem_nz_r <= (rem_r != '0);
      ceil_r   <= quo_r + TIME_W'(rem_r != '0);
      base_r   <= t_r - rem_r;
    end
  end

  // new release time and the comparisons of the decision
  assign nrt_sum = {1'b0, base_r} + (rem_nz_r ? {1'b0, p_r} : '0);

  always_ff @(posedge clk) begin
    if (cmd.fin2) begin
      nrt_r      <= nrt_sum[TIME_W] ? TMAX : nrt_sum[TIME_W-1:0];
      le_cur_r   <= (t_r <= cur_rt_r);
      tgt_lt_r   <= (ceil_r < idx_r);
      tgt_max_r  <= (ceil_r == TMAX);
      is_late_r  <= (t_r > dl_r);
      late_r     <= t_r - dl_r;
      ceil_gt_r  <= (ceil_r > idx_r);
      dist_adv_r <= ceil_r - idx_r;
      dist_cmp_r <= ceil_r + ~idx_r;
      idx_max_r  <= (idx_r == TMAX);
    end
  end

  // event outcome
  always_comb begin
    idx_nxt     = idx_r;
    skip_nxt    = skip_r;
    latecnt_nxt = latecnt_r;
    worst_nxt   = worst_r;
    ok_nxt      = 1'b0;
    rt_nxt      = cur_rt_r;
    if (!pzero_r) begin
      unique case (op_r)
        CMD_ADVANCE: begin
          if (le_cur_r) begin
            ok_nxt = (cur_rt_r != TMAX);
          end else if (!tgt_lt_r && !tgt_max_r) begin
            ok_nxt   = 1'b1;
            skip_nxt = skip_r + dist_adv_r;
            idx_nxt  = ceil_r;
            rt_nxt   = nrt_r;
          end
        end
        CMD_COMPLETE: begin
          if (!idx_max_r && !dl_ovf_r) begin
            ok_nxt = 1'b1;
            if (is_late_r) begin
              latecnt_nxt = latecnt_r + TIME_W'(1);
              if (late_r > worst_r) worst_nxt = late_r;
            end
            if (ceil_gt_r) begin
              idx_nxt  = ceil_r;
              skip_nxt = skip_r + dist_cmp_r;
              rt_nxt   = nrt_r;
            end else begin
              idx_nxt = idx_r + TIME_W'(1);
              rt_nxt  = dl_r;
            end
          end
        end
        CMD_CLEAR: begin
          ok_nxt      = 1'b1;
          idx_nxt     = '0;
          skip_nxt    = '0;
          latecnt_nxt = '0;
          worst_nxt   = '0;
          rt_nxt      = '0;
        end
        default: ok_nxt = 1'b0;
      endcase
    end
  end

  // schedule state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      skip_r    <= '0;
      latecnt_r <= '0;
      worst_r   <= '0;
    end else if (cmd.commit) begin
      idx_r     <= idx_nxt;
      skip_r    <= skip_nxt;
      latecnt_r <= latecnt_nxt;
      worst_r   <= worst_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r <= ok_nxt;
      rt_r <= rt_nxt;
    end
  end

  // state only changes on commit, which waits for a free slot
  assign out_ok             = ok_r;
  assign out_release_time   = rt_r;
  assign out_release_number = idx_r;
  assign out_skipped        = skip_r;
  assign out_late_count     = latecnt_r;
  assign out_worst_late     = worst_r;

endmodule

/* hdl/periodic_release_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_release_scheduler: fixed-period release schedule tracker
// Keeps the release index and lateness statistics of a nanosecond schedule
// and answers every advance, complete or clear event with one result item.
// ----------------------------------------------------------------------------
// Each event item is captured at its accepting edge; its result item becomes
// valid after 64 iterations of a shift-add multiplier (index times period)
// running beside a restoring divider (time over period), both one bit per
// cycle, then the two finishing states and a commit state that waits for a
// free output slot. A new item is taken in the cycle after the previous one
// has committed, so only one item is in flight at a time. The result sits in
// an output register, so the next item is accepted while it waits. The period
// register is written over the APB-style port at byte address 0 and should
// only change while no event is in flight.
module periodic_release_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  prs_in_if.sink                        in_ch,
  prs_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prs_pkg::ADDR_W-1:0]    paddr,
  input  logic [prs_pkg::TIME_W-1:0]    pwdata,
  output logic [prs_pkg::TIME_W-1:0]    prdata,
  output logic                          pready
);
  import prs_pkg::*;

  logic [TIME_W-1:0] period;
  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;

  assign pready = 1'b1;

  // configuration
  prs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .period  (period)
  );

  // sequencer
  prs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // datapath
  prs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .in_command         (in_ch.command),
    .in_time            (in_ch.event_time_ns),
    .period             (period),
    .out_ok             (out_ch.ok),
    .out_release_time   (out_ch.release_time_ns),
    .out_release_number (out_ch.release_number),
    .out_skipped        (out_ch.skipped_releases),
    .out_late_count     (out_ch.late_step_count),
    .out_worst_late     (out_ch.worst_lateness_ns)
  );

endmodule

/* hdl/prs_checker.sv */
// ----------------------------------------------------------------------------
// prs_checker: port-level checks of the scheduler
// Watches the channels of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module prs_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_ok,
  input  logic [prs_pkg::TIME_W-1:0]    out_release_number,
  input  logic [prs_pkg::TIME_W-1:0]    out_late_count,
  input  logic [prs_pkg::TIME_W-1:0]    out_worst_late
);
  import prs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_release_number))
    else $error("result changed while stalled");

  // one item in flight: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while the previous one is in flight");

  // any late step leaves a nonzero worst lateness
  a_late_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_late_count != '0) |-> (out_worst_late != '0))
    else $error("late steps counted with zero worst lateness");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind periodic_release_scheduler prs_checker u_prs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_ok             (out_ch.ok),
  .out_release_number (out_ch.release_number),
  .out_late_count     (out_ch.late_step_count),
  .out_worst_late     (out_ch.worst_lateness_ns)
);
